// ===== rtl/core/cda_pkg.sv =====
// Package for the calendar date advancer: sequencer states, command codes,
// calendar constants, the day-step status struct and month-length helpers.
// No dependencies.
`default_nettype none

package cda_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_STEP,
    ST_DONE
  } state_t;

  localparam logic CMD_SET     = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [15:0] BASE_YEAR     = 16'd1900;
  localparam logic [8:0]  LEAP_CYCLE    = 9'd400;
  localparam logic [8:0]  BASE_YEAR_MOD = 9'd300;  // 1900 mod 400
  localparam logic [8:0]  CENTURY_1     = 9'd100;
  localparam logic [8:0]  CENTURY_2     = 9'd200;
  localparam logic [8:0]  CENTURY_3     = 9'd300;
  localparam int unsigned NEW_YEAR_W    = 16;

  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_APR  = 4'd4;
  localparam logic [3:0] MONTH_JUN  = 4'd6;
  localparam logic [3:0] MONTH_SEP  = 4'd9;
  localparam logic [3:0] MONTH_NOV  = 4'd11;
  localparam logic [3:0] LAST_MONTH = 4'd12;

  localparam logic [4:0] LEN_LONG  = 5'd31;
  localparam logic [4:0] LEN_SHORT = 5'd30;
  localparam logic [4:0] LEN_LEAP  = 5'd29;
  localparam logic [4:0] LEN_FEB   = 5'd28;

  // Result of one calendar step
  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic       year_inc;
    logic       ovf;
  } step_t;

  // Leap status from the year taken modulo 400
  function automatic logic leap_of_mod(input logic [8:0] ymod);
    leap_of_mod = (ymod[1:0] == 2'b00) && (ymod != CENTURY_1) &&
                  (ymod != CENTURY_2) && (ymod != CENTURY_3);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    case (month)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = LEN_SHORT;
      MONTH_FEB: month_len = leap ? LEN_LEAP : LEN_FEB;
      default:   month_len = LEN_LONG;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cda_day_step.sv =====
// Single-day calendar step: next day and month, year carry and overflow.
// Depends on cda_pkg.
`default_nettype none

module cda_day_step
  import cda_pkg::*;
(
  input  wire logic [4:0] day,
  input  wire logic [3:0] month,
  input  wire logic       leap,
  input  wire logic       year_at_max,
  output step_t           step
);

  logic [4:0] len;

  always_comb begin
    len           = month_len(month, leap);
    step.day      = day;
    step.month    = month;
    step.year_inc = 1'b0;
    step.ovf      = 1'b0;
    if (day < len) begin
      step.day = day + 5'd1;
    end else if (month < LAST_MONTH) begin
      step.day   = 5'd1;
      step.month = month + 4'd1;
    end else if (year_at_max) begin
      // hold 31 December of the last year
      step.ovf = 1'b1;
    end else begin
      step.day      = 5'd1;
      step.month    = 4'd1;
      step.year_inc = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/calendar_date_advancer_unit.sv =====
// Top level of the calendar date advancer: stream channels, sequencer,
// date registers and output register. Depends on cda_pkg and cda_day_step.
`default_nettype none

// Usage
//   The block holds a Gregorian date, 1 January 1900 after reset. Each input
//   transaction on in_* carries one command in in_tuser: set loads the date
//   from in_tdata after checking it, advance moves the date forward by
//   day_count days. Every input transaction yields exactly one output
//   transaction on out_* carrying the current date and an error flag.
//   Set: the year is folded modulo 400 one bit per cycle over its 16 bits
//   (the remainder gives the leap status) before the result is registered.
//   Advance: one day-step unit takes one day per cycle until day_count days
//   are walked. Running past 31 December of the last year (2^YEAR_WIDTH - 1)
//   stops the walk there and flags an error.
//   in_tready is high only while the sequencer is idle; one item is worked
//   at a time. A finished result sits in the output register, so the next
//   input transaction is taken while out_tvalid waits; if the receiver still
//   stalls when that item finishes, the sequencer holds in its done state.
//   Reset (rst_n low, synchronous) returns the date to 1 January 1900 and
//   drops any item in progress or result not yet taken.

module calendar_date_advancer_unit
  import cda_pkg::*;
#(
  parameter int unsigned YEAR_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // [4:0] new_day, [8:5] new_month, [24:9] new_year, [40:25] day_count, rest zero
  input  wire logic [47:0] in_tdata,
  // [0] command
  input  wire logic [0:0]  in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // [4:0] cur_day, [8:5] cur_month, [24:9] cur_year, [25] error, rest zero
  output      logic [31:0] out_tdata
);

  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = '1;

  state_t state_r, state_nxt;

  logic                  cmd_r, cmd_nxt;
  logic [4:0]            nd_r, nd_nxt;
  logic [3:0]            nm_r, nm_nxt;
  logic [15:0]           ny_r, ny_nxt;
  logic [15:0]           shift_r, shift_nxt;
  logic [3:0]            bit_cnt_r, bit_cnt_nxt;
  logic [8:0]            rem_r, rem_nxt;
  logic [15:0]           cnt_r, cnt_nxt;
  logic                  err_r, err_nxt;

  logic [4:0]            day_r, day_nxt;
  logic [3:0]            month_r, month_nxt;
  logic [YEAR_WIDTH-1:0] year_r, year_nxt;
  logic [8:0]            ymod_r, ymod_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [4:0]            out_day_r, out_day_nxt;
  logic [3:0]            out_month_r, out_month_nxt;
  logic [15:0]           out_year_r, out_year_nxt;
  logic                  out_err_r, out_err_nxt;

  logic                  in_fire;
  logic                  done_fire;
  logic [9:0]            rem_shift;
  logic [9:0]            rem_fold;
  logic                  set_ok;
  step_t                 step;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // One bit of the modulo-400 fold of the set year
  assign rem_shift = {rem_r, shift_r[15]};
  assign rem_fold  = (rem_shift >= 10'(LEAP_CYCLE)) ? rem_shift - 10'(LEAP_CYCLE) : rem_shift;

  // Date check for a set command, once the fold has finished
  assign set_ok = (nm_r >= 4'd1) && (nm_r <= LAST_MONTH) &&
                  (ny_r >= BASE_YEAR) && (33'(ny_r) <= 33'(YEAR_MAX)) &&
                  (nd_r >= 5'd1) && (nd_r <= month_len(nm_r, leap_of_mod(rem_r)));

  cda_day_step u_step (
    .day         (day_r),
    .month       (month_r),
    .leap        (leap_of_mod(ymod_r)),
    .year_at_max (year_r == YEAR_MAX),
    .step        (step)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser[0] == CMD_SET) ? ST_MOD : ST_STEP;
        end
      end
      ST_MOD: begin
        if (bit_cnt_r == 4'(NEW_YEAR_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_STEP: begin
        if ((cnt_r == 16'd0) || step.ovf) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    nd_nxt        = nd_r;
    nm_nxt        = nm_r;
    ny_nxt        = ny_r;
    shift_nxt     = shift_r;
    bit_cnt_nxt   = bit_cnt_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    ymod_nxt      = ymod_r;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // capture the transaction and prime the fold and the day counter
          cmd_nxt     = in_tuser[0];
          nd_nxt      = in_tdata[4:0];
          nm_nxt      = in_tdata[8:5];
          ny_nxt      = in_tdata[24:9];
          shift_nxt   = in_tdata[24:9];
          cnt_nxt     = in_tdata[40:25];
          bit_cnt_nxt = 4'd0;
          rem_nxt     = 9'd0;
          err_nxt     = 1'b0;
        end
      end
      ST_MOD: begin
        shift_nxt   = {shift_r[14:0], 1'b0};
        rem_nxt     = rem_fold[8:0];
        bit_cnt_nxt = bit_cnt_r + 4'd1;
      end
      ST_STEP: begin
        if (cnt_r != 16'd0) begin
          if (step.ovf) begin
            err_nxt = 1'b1;
          end else begin
            day_nxt   = step.day;
            month_nxt = step.month;
            cnt_nxt   = cnt_r - 16'd1;
            if (step.year_inc) begin
              year_nxt = year_r + YEAR_WIDTH'(1);
              ymod_nxt = (ymod_r == LEAP_CYCLE - 9'd1) ? 9'd0 : ymod_r + 9'd1;
            end
          end
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          out_err_nxt = err_r;
          if (cmd_r == CMD_SET) begin
            out_err_nxt = !set_ok;
            if (set_ok) begin
              day_nxt   = nd_r;
              month_nxt = nm_r;
              year_nxt  = YEAR_WIDTH'(ny_r);
              ymod_nxt  = rem_r;
            end
          end
          out_day_nxt   = day_nxt;
          out_month_nxt = month_nxt;
          out_year_nxt  = 16'(year_nxt);
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      day_r       <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= YEAR_WIDTH'(BASE_YEAR);
      ymod_r      <= BASE_YEAR_MOD;
      bit_cnt_r   <= 4'd0;
      cnt_r       <= 16'd0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      ymod_r      <= ymod_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    nd_r        <= nd_nxt;
    nm_r        <= nm_nxt;
    ny_r        <= ny_nxt;
    shift_r     <= shift_nxt;
    rem_r       <= rem_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_err_r, out_year_r, out_month_r, out_day_r};

  // Held date always a plausible calendar position
  assert property (@(posedge clk) disable iff (!rst_n)
    (day_r != 5'd0) && (month_r != 4'd0) && (month_r <= LAST_MONTH))
    else $error("held date has day or month out of range");

  // Year residue stays below the leap cycle
  assert property (@(posedge clk) disable iff (!rst_n) ymod_r < LEAP_CYCLE)
    else $error("year residue out of range");

  // Busy after taking a transaction
  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_tready)
    else $error("input taken again while busy");

  // Each step cycle consumes exactly one day
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STEP) && (cnt_r != 16'd0) && !step.ovf) |=>
      (cnt_r == $past(cnt_r) - 16'd1))
    else $error("day counter did not advance by one");

endmodule

`default_nettype wire

// ===== verif/calendar_date_advancer_unit_tb.sv =====
// Testbench for calendar_date_advancer_unit: drives set and advance commands over the
// stream ports and checks each date against a calendar predictor held in a scoreboard.
// Depends on cda_pkg and the block's RTL only.

module calendar_date_advancer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  localparam int unsigned LAST_YEAR      = 65535;   // 2^YEAR_WIDTH - 1 at the default width
  localparam int unsigned RANDOM_ITEMS   = 76;
  localparam int unsigned DRAIN_CYCLES   = 40;
  // Longest quiet stretch of a correct run: a full 65535-day walk, plus
  // the set fold, a receiver stall and a sender gap; taken about four times
  localparam int unsigned WATCHDOG_LIMIT = 300000;

  // One date transaction as the block should report it
  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        err;
  } date_word_t;

  // Holds the calendar state, works out the date each accepted command
  // leaves behind and compares the block's reports against it in order.
  class date_scoreboard;
    int unsigned day_q;
    int unsigned month_q;
    int unsigned year_q;
    date_word_t  expected_dates[$];
    int unsigned failures;
    int unsigned sets;
    int unsigned rejected;
    int unsigned advances;
    int unsigned days_walked;
    int unsigned ceilings;

    function new();
      day_q       = 1;
      month_q     = 1;
      year_q      = BASE_YEAR;
      failures    = 0;
      sets        = 0;
      rejected    = 0;
      advances    = 0;
      days_walked = 0;
      ceilings    = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return LEN_SHORT;
        MONTH_FEB: return leap_year(y) ? LEN_LEAP : LEN_FEB;
        default:   return LEN_LONG;
      endcase
    endfunction

    // Step one day; refuse the step past 31 December of the last year
    function bit next_date();
      if (day_q < month_days(month_q, year_q)) begin
        day_q++;
        return 1'b1;
      end
      if (month_q < LAST_MONTH) begin
        day_q = 1;
        month_q++;
        return 1'b1;
      end
      if (year_q >= LAST_YEAR) return 1'b0;
      day_q   = 1;
      month_q = 1;
      year_q++;
      return 1'b1;
    endfunction

    function void note_command(logic cmd, logic [4:0] d, logic [3:0] m, logic [15:0] y,
                               logic [15:0] n);
      date_word_t w;
      bit         flag;
      flag = 1'b0;
      if (cmd == CMD_SET) begin
        sets++;
        if (m >= 1 && m <= LAST_MONTH && y >= BASE_YEAR && d >= 1 &&
            d <= month_days(m, y)) begin
          day_q   = d;
          month_q = m;
          year_q  = y;
        end else begin
          flag = 1'b1;
          rejected++;
        end
      end else begin
        advances++;
        for (int unsigned i = 0; i < n; i++) begin
          if (!next_date()) begin
            flag = 1'b1;
            ceilings++;
            break;
          end
          days_walked++;
        end
      end
      w.day   = day_q[4:0];
      w.month = month_q[3:0];
      w.year  = year_q[15:0];
      w.err   = flag;
      expected_dates.push_back(w);
    endfunction

    function void check_date(logic [31:0] bus);
      date_word_t w;
      if (expected_dates.size() == 0) begin
        failures++;
        $error("date transaction %h arrived with nothing pending", bus);
        return;
      end
      w = expected_dates.pop_front();
      if (bus[4:0] !== w.day) begin
        failures++;
        $error("cur_day: expected %0d, got %0d", w.day, bus[4:0]);
      end
      if (bus[8:5] !== w.month) begin
        failures++;
        $error("cur_month: expected %0d, got %0d", w.month, bus[8:5]);
      end
      if (bus[24:9] !== w.year) begin
        failures++;
        $error("cur_year: expected %0d, got %0d", w.year, bus[24:9]);
      end
      if (bus[25] !== w.err) begin
        failures++;
        $error("error: expected %0b, got %0b", w.err, bus[25]);
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [4:0] new_day, [8:5] new_month, [24:9] new_year, [40:25] day_count
  logic [0:0]  in_tuser;   // [0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [4:0] cur_day, [8:5] cur_month, [24:9] cur_year, [25] error

  date_scoreboard dates;
  int             send_calm = 0;
  int             recv_calm = 0;

  calendar_date_advancer_unit #(.YEAR_WIDTH(16)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // Draw the idle cycles before the next transaction, with
  // occasional runs where the side never idles
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(4, 12);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Offer one command and hold it until the block takes it. A zero gap
  // keeps tvalid high straight through from the previous transaction.
  task automatic push_command(logic cmd, logic [4:0] d, logic [3:0] m, logic [15:0] y,
                              logic [15:0] n);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, n, y, m, d};
    do @(posedge clk); while (!in_tready);
    dates.note_command(cmd, d, m, y, n);
  endtask

  // Set: day_count is don't-care, so fill it with noise
  task automatic set_date(logic [4:0] d, logic [3:0] m, logic [15:0] y);
    push_command(CMD_SET, d, m, y, 16'($urandom_range(0, 65535)));
  endtask

  // Advance: the date fields are don't-care, so fill them with noise
  task automatic advance_days(logic [15:0] n);
    push_command(CMD_ADVANCE, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                 16'($urandom_range(0, 65535)), n);
  endtask

  // Let every outstanding date come back before the sender carries on
  task automatic drain_dates();
    in_tvalid <= 1'b0;
    while (dates.pending() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random before each transaction, then check it
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int stall;
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      dates.check_date(out_tdata);
    end
  end

  // Watchdog: end the run if neither channel moves a transaction for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog expired with %0d dates outstanding", dates.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned d;
    int unsigned n;
    dates      = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_SET;
    in_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every rejection rule, the rollovers and the ceiling
    advance_days(16'd0);                  // zero days from reset leaves 1 Jan 1900
    set_date(5'd0, 4'd1, 16'd2000);       // day zero
    set_date(5'd1, 4'd0, 16'd2000);       // month zero
    set_date(5'd1, 4'd13, 16'd2000);      // month above December
    set_date(5'd31, 4'd15, 16'd65535);    // all-ones date fields, bad month
    set_date(5'd29, 4'd2, 16'd1900);      // century year is not leap
    set_date(5'd29, 4'd2, 16'd2000);      // fourth century is leap
    advance_days(16'd1);                  // leap February into March
    set_date(5'd31, 4'd4, 16'd2001);      // day past a 30-day month
    set_date(5'd1, 4'd1, 16'd1899);       // year below the base
    set_date(5'd15, 4'd6, 16'd0);         // year zero
    set_date(5'd28, 4'd2, 16'd2100);
    advance_days(16'd1);                  // non-leap February into March
    set_date(5'd29, 4'd2, 16'd2024);
    set_date(5'd31, 4'd12, 16'd1999);
    advance_days(16'd1);                  // December into the next year
    set_date(5'd31, 4'd1, 16'd2023);
    advance_days(16'd1);                  // end of month into the next one
    set_date(5'd30, 4'd12, 16'd65535);
    advance_days(16'd5);                  // run into the ceiling part way through
    advance_days(16'd0);                  // held at the ceiling, no error on zero days
    advance_days(16'd65535);              // refused at once from the ceiling
    set_date(5'd1, 4'd1, 16'd1900);
    advance_days(16'd65535);              // longest walk the block supports

    // Hold the sender until the block has answered everything
    drain_dates();

    // Random: mostly valid dates and short walks, some rejections and long walks
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_dates();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) y = $urandom_range(65530, LAST_YEAR);
        else if (pick < 3) y = $urandom_range(BASE_YEAR, LAST_YEAR);
        else y = $urandom_range(BASE_YEAR, 2500);
        m = $urandom_range(1, LAST_MONTH);
        d = $urandom_range(1, dates.month_days(m, y));
        set_date(d[4:0], m[3:0], y[15:0]);
      end else if (pick < 55) begin
        y = $urandom_range(BASE_YEAR, 2500);
        m = $urandom_range(1, LAST_MONTH);
        d = $urandom_range(1, 28);
        case ($urandom_range(0, 3))
          0: d = 0;
          1: begin
            m = $urandom_range(0, 3);
            if (m != 0) m = m + LAST_MONTH;
          end
          2: y = $urandom_range(0, BASE_YEAR - 1);
          default: begin
            len = dates.month_days(m, y);
            if (len == LEN_LONG) begin
              m   = MONTH_NOV;
              len = LEN_SHORT;
            end
            d = $urandom_range(len + 1, LEN_LONG);
          end
        endcase
        set_date(d[4:0], m[3:0], y[15:0]);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) n = $urandom_range(0, 65535);
        else if (pick < 20) n = $urandom_range(0, 4000);
        else n = $urandom_range(0, 400);
        advance_days(n[15:0]);
      end
    end

    drain_dates();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d set commands (%0d rejected) and %0d advances walking %0d days,",
             dates.sets, dates.rejected, dates.advances, dates.days_walked);
    $display("with %0d advances stopped at the last representable year.", dates.ceilings);
    if (dates.failures == 0 && dates.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== calendar_date_advancer_unit.f =====
rtl/core/cda_pkg.sv
rtl/core/cda_day_step.sv
rtl/core/calendar_date_advancer_unit.sv
verif/calendar_date_advancer_unit_tb.sv
